/* src/sct_pkg.sv */
// Shared types, constants and rounding helpers for the sine, cosine and tangent series block.
`default_nettype none

package sct_pkg;

  // Internal fraction bits of the series arithmetic.
  localparam int unsigned IF_BITS = 56;
  // Right shift of the sine and cosine sums for the tangent division, leaving 32 fraction bits.
  localparam int unsigned SH_TAN = IF_BITS - 32;
  // Pi with 60 fraction bits.
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  // One at the internal fraction width.
  localparam logic [63:0] ONE_IF = 64'd1 << IF_BITS;
  // Rounding bias for products scaled down by IF_BITS.
  localparam logic [127:0] ACC_INIT = 128'd1 << (IF_BITS - 1);

  // Divisor and remainder width of the shared divider.
  localparam int unsigned DIV_W = 40;
  // Steps of the shared unit.
  localparam int unsigned MUL_STEPS = 4;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W = 6;

  // Operation codes.
  localparam logic [1:0] OP_SIN = 2'd0;
  localparam logic [1:0] OP_COS = 2'd1;
  localparam logic [1:0] OP_TAN = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_POLE = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // Saturation values of the tangent.
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_RED_W,
    S_FOLD,
    S_SQ,
    S_SQ_W,
    S_INIT,
    S_CHK,
    S_MUL_W,
    S_DIV_W,
    S_SER_END,
    S_TAN1,
    S_TAN2,
    S_TAN_W,
    S_OUT
  } state_t;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

  // Status of the shared multiply/divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

  // Magnitude of a signed 64-bit value.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Two's complement negation when neg is set.
  function automatic logic [63:0] neg_if(input logic [63:0] m, input logic neg);
    return neg ? (~m + 64'd1) : m;
  endfunction

  // Magnitude of v shifted right by sh, rounded to nearest, ties away from zero.
  function automatic logic [63:0] rnd_mag(input logic signed [63:0] v, input int unsigned sh);
    logic [63:0] m;
    m = mag64(v);
    return (m + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

`default_nettype wire

/* src/sct_mdu.sv */
// Shared multiply/divide unit: 64x64 rounded product in four 32x32 steps, 64-step divider.
`default_nettype none

module sct_mdu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sct_pkg::mdu_req_t          req,
  input  wire logic [63:0]                opa,
  input  wire logic [63:0]                opb,
  output sct_pkg::mdu_rsp_t               rsp,
  output logic [63:0]                     result
);
  import sct_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic              div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              last;
  logic              take;

  logic [63:0]       a_r;
  logic [63:0]       b_r;
  logic [63:0]       prod_r;
  logic [1:0]        psh_r;
  logic [127:0]      acc_r;
  logic [63:0]       quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;

  logic [31:0]       pa;
  logic [31:0]       pb;
  logic [63:0]       pp;
  logic [1:0]        psh;
  logic [127:0]      addend;
  logic [DIV_W:0]    trial;
  logic              ge;

  assign take = req.start && !busy_r;
  assign last = div_r ? (cnt_r == CNT_W'(DIV_STEPS - 1)) : (cnt_r == CNT_W'(MUL_STEPS));

  // Partial product selection: low*low, low*high, high*low, high*high.
  assign pa  = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign pb  = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp  = pa * pb;
  assign psh = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};

  // Place the registered partial product at its 32-bit offset.
  always_comb begin
    case (psh_r)
      2'd0:    addend = {64'd0, prod_r};
      2'd1:    addend = {32'd0, prod_r, 32'd0};
      2'd2:    addend = {prod_r, 64'd0};
      default: addend = '0;
    endcase
  end

  // One restoring division step.
  assign trial = {rem_r, quo_r[63]};
  assign ge    = trial >= {1'b0, dvs_r};

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        div_r  <= req.is_div;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand capture, accumulation and division steps.
  always_ff @(posedge clk) begin
    if (take) begin
      a_r   <= opa;
      b_r   <= opb;
      quo_r <= opa;
      rem_r <= '0;
      dvs_r <= opb[DIV_W-1:0];
      acc_r <= ACC_INIT;
    end else if (busy_r) begin
      if (div_r) begin
        quo_r <= {quo_r[62:0], ge};
        rem_r <= ge ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];
      end else begin
        if (cnt_r < CNT_W'(MUL_STEPS)) begin
          prod_r <= pp;
          psh_r  <= psh;
        end
        if (cnt_r != '0) begin
          acc_r <= acc_r + addend;
        end
      end
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign result    = div_r ? quo_r : acc_r[IF_BITS+63:IF_BITS];

endmodule

`default_nettype wire

/* src/sine_cosine_tangent_series.sv */
// Top level: angle reduction, Taylor series sequencer, tangent division and register port.
// Sine or cosine sums at most MAX_TERMS series terms; tangent sums both series and then divides, unless
// a pole ends it early; the reduction is a 5-step compare and subtract at FRAC_BITS 24, and each term
// is a multiply and a bit-serial divide.
// Throughput: one item at a time; a finished result waits in the output register meanwhile.
// Reset: synchronous active-low rst_n idles the sequencer and sets pole_threshold to 1.
`default_nettype none

module sine_cosine_tangent_series #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] angle
  input  wire logic [1:0]  in_tuser,    // [1:0] operation
  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] value
  output logic [1:0]       out_tuser,   // [1:0] status
  // Register port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import sct_pkg::*;

  localparam int NW = $clog2(MAX_TERMS + 1);
  localparam int KW = NW + 1;
  localparam int DW = 2 * KW;
  localparam int unsigned SH_FB = IF_BITS - FRAC_BITS;
  localparam logic signed [63:0] PI_FB =
    64'((PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
  localparam logic signed [63:0] TP_FB =
    64'((PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS));
  localparam logic signed [63:0] NPI_FB = -PI_FB;
  localparam logic REG_POLE_THRESH = 1'b0;
  // Quotient bits of a 32-bit angle magnitude divided by two pi.
  localparam int TP_BITS = $clog2(TP_FB);
  localparam int RED_STEPS = (TP_BITS >= 32) ? 1 : 32 - TP_BITS;

  state_t             state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic signed [31:0] angle_r, angle_nxt;
  logic               cos_r, cos_nxt;
  logic signed [63:0] x_r, x_nxt;
  logic [63:0]        x2_r, x2_nxt;
  logic signed [63:0] term_r, term_nxt;
  logic signed [63:0] sum_r, sum_nxt;
  logic signed [63:0] si_r, si_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   smag_r, smag_nxt;
  logic               sneg_r, sneg_nxt;
  logic [DIV_W-1:0]   cmag_r, cmag_nxt;
  logic               cneg_r, cneg_nxt;
  logic [31:0]        res_value_r, res_value_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_value_r, out_value_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [15:0]        thresh_r;

  mdu_req_t           mdu_req;
  mdu_rsp_t           mdu_rsp;
  logic [63:0]        mdu_a;
  logic [63:0]        mdu_b;
  logic [63:0]        mdu_res;

  logic [31:0]        ang_mag;
  logic signed [63:0] red_sub;
  logic signed [63:0] red_step;
  logic signed [63:0] xf;
  logic [KW-1:0]      kk, kk_lo, kk_hi;
  logic [DW-1:0]      d_val;
  logic [63:0]        cout_mag;
  logic               s_neg_eff;
  logic               tneg;
  logic               load_out;
  logic               cfg_wr;

  // Shared arithmetic unit.
  sct_mdu u_mdu (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mdu_req),
    .opa       (mdu_a),
    .opb       (mdu_b),
    .rsp       (mdu_rsp),
    .result    (mdu_res)
  );

  // Operand helpers.
  assign ang_mag   = angle_r[31] ? (~angle_r + 32'd1) : angle_r;
  assign cout_mag  = rnd_mag(sum_r, SH_FB);
  assign s_neg_eff = sneg_r && (smag_r != '0);
  assign tneg      = s_neg_eff != cneg_r;

  // Reduction step: subtract two pi times the current quotient bit weight when it fits.
  assign red_sub  = TP_FB <<< cnt_r;
  assign red_step = (x_r >= red_sub) ? (x_r - red_sub) : x_r;

  // Series divisor: (2n)(2n+1) for sine, (2n-1)(2n) for cosine.
  assign kk    = {cnt_r, 1'b0};
  assign kk_lo = cos_r ? (kk - KW'(1)) : kk;
  assign kk_hi = cos_r ? kk : (kk + KW'(1));
  assign d_val = DW'(kk_lo) * DW'(kk_hi);

  // Fold the remainder into the range from minus pi to pi.
  always_comb begin
    if (x_r > PI_FB) begin
      xf = x_r - TP_FB;
    end else if (x_r < NPI_FB) begin
      xf = x_r + TP_FB;
    end else begin
      xf = x_r;
    end
  end

  // Sequencer: next state, datapath updates and unit requests.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    angle_nxt      = angle_r;
    cos_nxt        = cos_r;
    x_nxt          = x_r;
    x2_nxt         = x2_r;
    term_nxt       = term_r;
    sum_nxt        = sum_r;
    si_nxt         = si_r;
    cnt_nxt        = cnt_r;
    smag_nxt       = smag_r;
    sneg_nxt       = sneg_r;
    cmag_nxt       = cmag_r;
    cneg_nxt       = cneg_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    mdu_req        = '0;
    mdu_a          = '0;
    mdu_b          = '0;
    in_tready      = 1'b0;
    load_out       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          angle_nxt = in_tdata;
          cos_nxt   = (in_tuser == OP_COS);
          if (in_tuser == OP_SIN || in_tuser == OP_COS || in_tuser == OP_TAN) begin
            state_nxt = S_RED;
          end else begin
            res_value_nxt  = '0;
            res_status_nxt = ST_OK;
            state_nxt      = S_OUT;
          end
        end
      end
      S_RED: begin
        x_nxt     = 64'(ang_mag);
        cnt_nxt   = NW'(RED_STEPS - 1);
        state_nxt = S_RED_W;
      end
      S_RED_W: begin
        // One compare and subtract per quotient bit; the remainder takes the angle's sign.
        if (cnt_r == '0) begin
          x_nxt     = neg_if(red_step, angle_r[31]);
          state_nxt = S_FOLD;
        end else begin
          x_nxt   = red_step;
          cnt_nxt = cnt_r - NW'(1);
        end
      end
      S_FOLD: begin
        x_nxt     = xf <<< SH_FB;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        mdu_req.start = 1'b1;
        mdu_a         = mag64(x_r);
        mdu_b         = mag64(x_r);
        state_nxt     = S_SQ_W;
      end
      S_SQ_W: begin
        if (mdu_rsp.done) begin
          x2_nxt    = mdu_res;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        term_nxt  = cos_r ? ONE_IF : x_r;
        sum_nxt   = cos_r ? ONE_IF : x_r;
        cnt_nxt   = NW'(1);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // Stop on a zero term or when the term budget is spent.
        if (term_r == '0 || cnt_r >= NW'(MAX_TERMS)) begin
          state_nxt = S_SER_END;
        end else begin
          mdu_req.start = 1'b1;
          mdu_a         = mag64(term_r);
          mdu_b         = x2_r;
          state_nxt     = S_MUL_W;
        end
      end
      S_MUL_W: begin
        // Rounded division of the product magnitude by the series divisor.
        if (mdu_rsp.done) begin
          mdu_req.start  = 1'b1;
          mdu_req.is_div = 1'b1;
          mdu_a          = mdu_res + 64'(d_val >> 1);
          mdu_b          = 64'(d_val);
          state_nxt      = S_DIV_W;
        end
      end
      S_DIV_W: begin
        // The next term has the opposite sign of the current one.
        if (mdu_rsp.done) begin
          term_nxt  = neg_if(mdu_res, !term_r[63]);
          sum_nxt   = term_r[63] ? (sum_r + mdu_res) : (sum_r - mdu_res);
          cnt_nxt   = cnt_r + NW'(1);
          state_nxt = S_CHK;
        end
      end
      S_SER_END: begin
        if (op_r == OP_TAN) begin
          if (!cos_r) begin
            si_nxt    = sum_r;
            cos_nxt   = 1'b1;
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_TAN1;
          end
        end else begin
          res_value_nxt  = 32'(neg_if(rnd_mag(sum_r, SH_FB), sum_r[63]));
          res_status_nxt = ST_OK;
          state_nxt      = S_OUT;
        end
      end
      S_TAN1: begin
        if (cout_mag < 64'(thresh_r)) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_POLE;
          state_nxt      = S_OUT;
        end else begin
          smag_nxt  = DIV_W'(rnd_mag(si_r, SH_TAN));
          sneg_nxt  = si_r[63];
          cmag_nxt  = DIV_W'(rnd_mag(sum_r, SH_TAN));
          cneg_nxt  = sum_r[63];
          state_nxt = S_TAN2;
        end
      end
      S_TAN2: begin
        // A cosine that rounds to zero saturates with the sign of the sine.
        if (cmag_r == '0) begin
          res_value_nxt  = s_neg_eff ? SAT_NEG : SAT_POS;
          res_status_nxt = ST_SAT;
          state_nxt      = S_OUT;
        end else begin
          mdu_req.start  = 1'b1;
          mdu_req.is_div = 1'b1;
          mdu_a          = (64'(smag_r) << FRAC_BITS) + 64'(cmag_r >> 1);
          mdu_b          = 64'(cmag_r);
          state_nxt      = S_TAN_W;
        end
      end
      S_TAN_W: begin
        if (mdu_rsp.done) begin
          if (!tneg && mdu_res > 64'(SAT_POS)) begin
            res_value_nxt  = SAT_POS;
            res_status_nxt = ST_SAT;
          end else if (tneg && mdu_res > 64'(SAT_NEG)) begin
            res_value_nxt  = SAT_NEG;
            res_status_nxt = ST_SAT;
          end else begin
            res_value_nxt  = 32'(neg_if(mdu_res, tneg));
            res_status_nxt = ST_OK;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt  = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_value_nxt  = load_out ? res_value_r : out_value_r;
    out_status_nxt = load_out ? res_status_r : out_status_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    angle_r      <= angle_nxt;
    cos_r        <= cos_nxt;
    x_r          <= x_nxt;
    x2_r         <= x2_nxt;
    term_r       <= term_nxt;
    sum_r        <= sum_nxt;
    si_r         <= si_nxt;
    cnt_r        <= cnt_nxt;
    smag_r       <= smag_nxt;
    sneg_r       <= sneg_nxt;
    cmag_r       <= cmag_nxt;
    cneg_r       <= cneg_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // Register port: pole threshold at word address zero.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 16'd1;
    end else if (cfg_wr && cfg_paddr[2] == REG_POLE_THRESH) begin
      thresh_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_POLE_THRESH) ? {16'd0, thresh_r} : 32'd0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // One item at a time: the input closes right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while an item is in work");

  // The shared unit is never restarted while it is still working.
  a_mdu_free: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_req.start |-> !mdu_rsp.busy)
    else $error("shared unit started while busy");

  // A pole result always carries a zero value.
  a_pole_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_POLE) |-> (out_tdata == 32'd0))
    else $error("pole status with nonzero value");

endmodule

`default_nettype wire
